@@ rtl/lpc_pkg.sv @@
// lpc_pkg: shared types, codes and helper functions for the lift position controller.
// Used by lpc_ctrl, lpc_datapath, lift_position_controller_core and lpc_checker.
// No dependencies.
package lpc_pkg;

  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 18;
  localparam int DIV_STEPS   = 8;

  // request codes
  localparam logic [2:0] REQ_TICK = 3'd0;
  localparam logic [2:0] REQ_GOTO = 3'd1;
  localparam logic [2:0] REQ_STOP = 3'd2;
  localparam logic [2:0] REQ_UP   = 3'd3;
  localparam logic [2:0] REQ_DOWN = 3'd4;

  // drive modes
  localparam logic [1:0] MODE_COAST = 2'd0;
  localparam logic [1:0] MODE_FWD   = 2'd1;
  localparam logic [1:0] MODE_REV   = 2'd2;
  localparam logic [1:0] MODE_BRAKE = 2'd3;

  // limit events
  localparam logic [1:0] LIM_NONE    = 2'd0;
  localparam logic [1:0] LIM_UPPER   = 2'd1;
  localparam logic [1:0] LIM_LOWER   = 2'd2;
  localparam logic [1:0] LIM_ENDSTOP = 2'd3;

  // register indexes
  localparam logic [2:0] REG_TOL    = 3'd0;
  localparam logic [2:0] REG_ZONE   = 3'd1;
  localparam logic [2:0] REG_MAX    = 3'd2;
  localparam logic [2:0] REG_MIN    = 3'd3;
  localparam logic [2:0] REG_MANUAL = 3'd4;
  localparam logic [2:0] REG_LOWER  = 3'd5;
  localparam logic [2:0] REG_UPPER  = 3'd6;

  // register reset values
  localparam logic [15:0] RST_TOL    = 16'd100;
  localparam logic [15:0] RST_ZONE   = 16'd800;
  localparam logic [7:0]  RST_MAX    = 8'd150;
  localparam logic [7:0]  RST_MIN    = 8'd50;
  localparam logic [7:0]  RST_MANUAL = 8'd150;
  localparam logic [17:0] RST_LOWER  = 18'd0;
  localparam logic [17:0] RST_UPPER  = 18'd20000;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_APPLY = 7'b0000010,
    S_ERR   = 7'b0000100,
    S_CTRL  = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_FIN   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  typedef struct packed {
    logic cap;
    logic apply;
    logic err;
    logic ctrl;
    logic div;
    logic fin;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_free;
  } dp_stat_t;

  // quadrature step from {previous A/B, current A/B}
  function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
    logic signed [1:0] res;
    case (idx) inside
      4'd2, 4'd4, 4'd11, 4'd13: res = 2'sb01;
      4'd1, 4'd7, 4'd8, 4'd14:  res = 2'sb11;
      default:                  res = 2'sb00;
    endcase
    return res;
  endfunction

  function automatic logic [1:0] mode_of(input logic signed [8:0] spd);
    logic [1:0] m;
    if (spd == 9'sd0) begin
      m = MODE_COAST;
    end else if (spd[8]) begin
      m = MODE_REV;
    end else begin
      m = MODE_FWD;
    end
    return m;
  endfunction

endpackage

@@ rtl/lpc_ctrl.sv @@
// lpc_ctrl: sequencer for one control tick (apply, error, control, ramp divide, output).
// Depends on lpc_pkg.
module lpc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  lpc_pkg::dp_stat_t stat,
  output lpc_pkg::dp_cmd_t  cmd
);

  lpc_pkg::state_t state_r, state_nxt;
  logic [2:0] div_cnt_r, div_cnt_nxt;

  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    cmd         = '0;
    case (state_r)
      lpc_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = lpc_pkg::S_APPLY;
        end
      end
      lpc_pkg::S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = lpc_pkg::S_ERR;
      end
      lpc_pkg::S_ERR: begin
        cmd.err   = 1'b1;
        state_nxt = lpc_pkg::S_CTRL;
      end
      lpc_pkg::S_CTRL: begin
        cmd.ctrl    = 1'b1;
        div_cnt_nxt = '0;
        state_nxt   = stat.need_div ? lpc_pkg::S_DIV : lpc_pkg::S_OUT;
      end
      lpc_pkg::S_DIV: begin
        cmd.div     = 1'b1;
        div_cnt_nxt = div_cnt_r + 3'd1;
        if (div_cnt_r == 3'(lpc_pkg::DIV_STEPS - 1)) begin
          state_nxt = lpc_pkg::S_FIN;
        end
      end
      lpc_pkg::S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = lpc_pkg::S_OUT;
      end
      lpc_pkg::S_OUT: begin
        if (stat.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = lpc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = lpc_pkg::S_IDLE;
      end
    endcase
  end

  assign in_ready = (state_r == lpc_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= lpc_pkg::S_IDLE;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

endmodule

@@ rtl/lpc_datapath.sv @@
// lpc_datapath: config registers, encoder count, limit checks, speed ramp with
// shift-subtract divider, and the output register. Depends on lpc_pkg.
module lpc_datapath #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lpc_pkg::dp_cmd_t                  cmd,
  output lpc_pkg::dp_stat_t                 stat,
  input  logic [lpc_pkg::IN_TDATA_W-1:0]    in_data,
  input  logic [lpc_pkg::IN_TUSER_W-1:0]    in_user,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lpc_pkg::OUT_TDATA_W-1:0]   out_data,
  input  logic                              cfg_fire,
  input  logic [lpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lpc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int EW = ((COUNT_WIDTH > 18) ? COUNT_WIDTH : 18) + 1;
  localparam int PW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

  // config
  logic [15:0]        tol_r, zone_r;
  logic [7:0]         max_r, min_r, man_r;
  logic signed [17:0] lo_r, hi_r;

  // controller state
  logic [1:0]             enc_last_r;
  logic [COUNT_WIDTH-1:0] count_r;
  logic signed [17:0]     target_r;
  logic                   active_r, arrived_r;
  logic signed [8:0]      speed_r;
  logic [1:0]             mode_r;

  // captured word
  logic [2:0]         req_r;
  logic signed [17:0] tgt_r;
  logic [1:0]         enc_r;
  logic               endstop_r;

  // work registers
  logic [1:0]    lim_ev_r;
  logic          arr_ev_r;
  logic [EW-1:0] ae_r;
  logic          err_neg_r;
  logic [23:0]   rem_r, dsh_r;
  logic [7:0]    quo_r;
  logic          qneg_r;

  logic                           out_valid_r;
  logic [lpc_pkg::OUT_TDATA_W-1:0] out_data_r;

  // ---- apply: command, encoder, limits
  logic                   active_a, arrived_a;
  logic signed [17:0]     target_a;
  logic signed [8:0]      speed_a, man_s;
  logic [1:0]             mode_a, lim_a;
  logic [COUNT_WIDTH-1:0] count_n;
  logic signed [EW-1:0]   cnt_x, lo_x, hi_x;

  assign man_s   = signed'({1'b0, man_r});
  assign count_n = count_r + COUNT_WIDTH'(lpc_pkg::quad_step({enc_last_r, enc_r}));
  assign cnt_x   = EW'(signed'(count_n));
  assign lo_x    = EW'(lo_r);
  assign hi_x    = EW'(hi_r);

  always_comb begin
    active_a  = active_r;
    arrived_a = arrived_r;
    target_a  = target_r;
    speed_a   = speed_r;
    mode_a    = mode_r;
    lim_a     = lpc_pkg::LIM_NONE;
    case (req_r)
      lpc_pkg::REQ_GOTO: begin
        target_a  = (tgt_r < lo_r) ? lo_r : ((tgt_r > hi_r) ? hi_r : tgt_r);
        active_a  = 1'b1;
        arrived_a = 1'b0;
      end
      lpc_pkg::REQ_STOP: begin
        active_a = 1'b0;
        speed_a  = '0;
        mode_a   = lpc_pkg::MODE_COAST;
      end
      lpc_pkg::REQ_UP: begin
        active_a = 1'b0;
        speed_a  = man_s;
        mode_a   = lpc_pkg::mode_of(man_s);
      end
      lpc_pkg::REQ_DOWN: begin
        active_a = 1'b0;
        speed_a  = -man_s;
        mode_a   = lpc_pkg::mode_of(-man_s);
      end
      default: ;
    endcase
    if (cnt_x > hi_x && speed_a > 9'sd0) begin
      speed_a  = '0;
      mode_a   = lpc_pkg::MODE_BRAKE;
      active_a = 1'b0;
      lim_a    = lpc_pkg::LIM_UPPER;
    end
    if (cnt_x <= lo_x && speed_a < 9'sd0) begin
      speed_a  = '0;
      mode_a   = lpc_pkg::MODE_BRAKE;
      active_a = 1'b0;
      lim_a    = lpc_pkg::LIM_LOWER;
    end
    if (endstop_r) begin
      speed_a  = '0;
      mode_a   = lpc_pkg::MODE_BRAKE;
      active_a = 1'b0;
      lim_a    = lpc_pkg::LIM_ENDSTOP;
    end
  end

  // ---- error
  logic signed [EW-1:0] err;
  assign err = EW'(target_r) - EW'(signed'(count_r));

  // ---- control decision
  logic              in_tol, far;
  logic [15:0]       diff, den;
  logic [7:0]        span;
  logic signed [8:0] max_s;
  assign in_tol = (ae_r <= EW'(tol_r));
  assign far    = (ae_r >= EW'(zone_r)) || (zone_r <= tol_r);
  assign diff   = ae_r[15:0] - tol_r;
  assign den    = zone_r - tol_r;
  assign span   = (max_r >= min_r) ? (max_r - min_r) : (min_r - max_r);
  assign max_s  = signed'({1'b0, max_r});

  assign stat.need_div = active_r && !in_tol && !far;
  assign stat.out_free = !out_valid_r || out_ready;

  // ---- ramp finish
  logic signed [9:0] q_s, mag_s;
  logic signed [8:0] ramp_spd;
  assign q_s      = qneg_r ? -signed'({2'b00, quo_r}) : signed'({2'b00, quo_r});
  assign mag_s    = signed'({2'b00, min_r}) + q_s;
  assign ramp_spd = err_neg_r ? -signed'({1'b0, mag_s[7:0]}) : signed'({1'b0, mag_s[7:0]});

  // ---- output word
  logic signed [PW-1:0] pos_w;
  logic [7:0]           duty;
  assign pos_w = PW'(signed'(count_r));
  assign duty  = speed_r[8] ? 8'(-speed_r) : speed_r[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r      <= lpc_pkg::RST_TOL;
      zone_r     <= lpc_pkg::RST_ZONE;
      max_r      <= lpc_pkg::RST_MAX;
      min_r      <= lpc_pkg::RST_MIN;
      man_r      <= lpc_pkg::RST_MANUAL;
      lo_r       <= signed'(lpc_pkg::RST_LOWER);
      hi_r       <= signed'(lpc_pkg::RST_UPPER);
      enc_last_r <= '0;
      count_r    <= '0;
      target_r   <= '0;
      active_r   <= 1'b0;
      arrived_r  <= 1'b0;
      speed_r    <= '0;
      mode_r     <= lpc_pkg::MODE_COAST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_fire) begin
        case (cfg_index)
          lpc_pkg::REG_TOL:    tol_r  <= cfg_data[15:0];
          lpc_pkg::REG_ZONE:   zone_r <= cfg_data[15:0];
          lpc_pkg::REG_MAX:    max_r  <= cfg_data[7:0];
          lpc_pkg::REG_MIN:    min_r  <= cfg_data[7:0];
          lpc_pkg::REG_MANUAL: man_r  <= cfg_data[7:0];
          lpc_pkg::REG_LOWER:  lo_r   <= signed'(cfg_data);
          lpc_pkg::REG_UPPER:  hi_r   <= signed'(cfg_data);
          default: ;
        endcase
      end
      if (cmd.apply) begin
        enc_last_r <= enc_r;
        count_r    <= count_n;
        target_r   <= target_a;
        active_r   <= active_a;
        arrived_r  <= arrived_a;
        speed_r    <= speed_a;
        mode_r     <= mode_a;
      end
      if (cmd.ctrl && active_r) begin
        if (in_tol) begin
          speed_r <= '0;
          mode_r  <= lpc_pkg::MODE_COAST;
          if (!arrived_r) begin
            arrived_r <= 1'b1;
          end
        end else begin
          arrived_r <= 1'b0;
          if (far) begin
            speed_r <= err_neg_r ? -max_s : max_s;
            mode_r  <= lpc_pkg::mode_of(err_neg_r ? -max_s : max_s);
          end
        end
      end
      if (cmd.fin) begin
        speed_r <= ramp_spd;
        mode_r  <= lpc_pkg::mode_of(ramp_spd);
      end
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and work registers
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req_r     <= in_user;
      tgt_r     <= signed'(in_data[17:0]);
      enc_r     <= {in_data[18], in_data[19]};
      endstop_r <= in_data[20];
    end
    if (cmd.apply) begin
      lim_ev_r <= lim_a;
      arr_ev_r <= 1'b0;
    end
    if (cmd.err) begin
      err_neg_r <= err[EW-1];
      ae_r      <= err[EW-1] ? EW'(-err) : EW'(err);
    end
    if (cmd.ctrl) begin
      if (active_r && in_tol && !arrived_r) begin
        arr_ev_r <= 1'b1;
      end
      rem_r  <= 24'(diff) * 24'(span);
      dsh_r  <= {1'b0, den, 7'b0};
      quo_r  <= '0;
      qneg_r <= (max_r < min_r);
    end
    if (cmd.div) begin
      if (rem_r >= dsh_r) begin
        rem_r <= rem_r - dsh_r;
        quo_r <= {quo_r[6:0], 1'b1};
      end else begin
        quo_r <= {quo_r[6:0], 1'b0};
      end
      dsh_r <= {1'b0, dsh_r[23:1]};
    end
    if (cmd.load) begin
      out_data_r <= {1'b0, active_r, lim_ev_r, arr_ev_r, arrived_r, pos_w[31:0], duty, mode_r};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/lift_position_controller_core.sv @@
// lift_position_controller_core: top level of the lift position controller.
// Instantiates lpc_ctrl and lpc_datapath; depends on lpc_pkg.
//
// Usage:
//   in_*  : one word per control tick. in_tuser = request code, in_tdata =
//           target, encoder A/B levels and endstop flag.
//   out_* : one result word per tick: drive mode, duty, position, arrival and
//           limit flags.
//   cfg_* : register writes (index 0..6), always accepted; write only while idle.
// Timing: a tick runs apply, error and control steps and is then loaded into the
//   output register; in the linear ramp region the 8-step shift-subtract divider
//   and a finish step come before the load. in_tready returns the cycle after
//   the load, so a new word is taken only once the last tick has been loaded.
// Reset (rst_n low, synchronous): registers to defaults, position 0, coast,
//   output empty.
// Stall: a finished word waits in the output register while the next tick is
//   taken and worked; a second result then holds until out_tready.
module lift_position_controller_core #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [17:0] cmd_target, [18] enc_a, [19] enc_b, [20] endstop_hit, [23:21] zero
  input  logic [lpc_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [2:0] req_type
  input  logic [lpc_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [1:0] drive_mode, [9:2] duty, [41:10] position, [42] arrived,
  // [43] arrived_event, [45:44] limit_event, [46] positioning, [47] zero
  output logic [lpc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lpc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  lpc_pkg::dp_cmd_t  cmd;
  lpc_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  lpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lpc_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_tdata),
    .in_user   (in_tuser),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .cfg_fire  (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

@@ rtl/lpc_checker.sv @@
// lpc_checker: port-level assertions for lift_position_controller_core, bound below.
// Depends on lpc_pkg.
module lpc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [lpc_pkg::OUT_TDATA_W-1:0] out_tdata
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word taken while a tick is in work");

  a_idle_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == lpc_pkg::MODE_COAST ||
                   out_tdata[1:0] == lpc_pkg::MODE_BRAKE) |-> out_tdata[9:2] == 8'd0)
    else $error("nonzero duty while coasting or braking");

  a_limit_brake: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[45:44] != lpc_pkg::LIM_NONE |->
      out_tdata[1:0] == lpc_pkg::MODE_BRAKE && !out_tdata[46])
    else $error("limit event without brake");

  a_arrive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[43] |-> out_tdata[42] && out_tdata[46])
    else $error("arrival event without arrival");

endmodule

bind lift_position_controller_core lpc_checker u_lpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ test/lift_position_controller_core_test.sv @@
// Self-checking testbench for lift_position_controller_core: a directed table, then
// randomized control ticks across several register settings, checked against a
// behavioral model of the lift controller. Depends on lpc_pkg and the core RTL.
`timescale 1ns / 100ps

module lift_position_controller_core_test;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES = 8;
  localparam int PER_PHASE = 116;

  localparam logic [2:0] REQ_SPARE5 = 3'd5;
  localparam logic [2:0] REQ_SPARE6 = 3'd6;
  localparam logic [2:0] REQ_SPARE7 = 3'd7;
  localparam logic [2:0] REG_SPARE = 3'd7;

  // quarter step indexed by {previous A/B, current A/B}
  localparam int QUAD [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};
  localparam logic [1:0] FWD_NEXT [4] = '{2'd2, 2'd0, 2'd3, 2'd1};
  localparam logic [1:0] BACK_NEXT [4] = '{2'd1, 2'd3, 2'd0, 2'd2};

  typedef struct packed {
    logic [2:0] req;
    logic signed [17:0] target;
    logic a;
    logic b;
    logic stop;
  } tick_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] duty;
    logic [31:0] position;
    logic arrived;
    logic arr_ev;
    logic [1:0] lim;
    logic seeking;
  } lift_word_t;

  typedef struct packed {
    tick_t t;
    logic typed;
    lift_word_t want;
  } tick_row_t;

  localparam lift_word_t ANY_WORD = '0;
  localparam lift_word_t RESET_WORD = '{lpc_pkg::MODE_COAST, 8'd0, 32'd0, 1'b0, 1'b0,
                                        lpc_pkg::LIM_NONE, 1'b0};

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [lpc_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic [lpc_pkg::IN_TUSER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [lpc_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lpc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lpc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  lift_position_controller_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // model state
  logic [15:0] tol_cfg, zone_cfg;
  logic [7:0] top_speed, floor_speed, jog_speed;
  logic [17:0] low_stop, high_stop;
  logic [1:0] enc_last;
  logic [31:0] pos_count;
  longint goal;
  logic seeking, settled;
  longint speed_now;
  logic [1:0] mode_now;

  lift_word_t expected_words [$];
  logic [17:0] reg_plan [8];
  int errors = 0;
  int words_seen = 0;
  int burst_left;
  bit hold_go = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    if (errors <= 100) begin
      $display("result %0d: %s got %0d want %0d", words_seen, what, got, want);
    end
  endtask

  function automatic void set_drive(input longint s);
    if (s > 255) s = 255;
    if (s < -255) s = -255;
    speed_now = s;
    mode_now = (s == 0) ? lpc_pkg::MODE_COAST :
               ((s > 0) ? lpc_pkg::MODE_FWD : lpc_pkg::MODE_REV);
  endfunction

  task automatic predict_motor_word(input tick_t t, output lift_word_t w);
    longint lo, hi, tgt, cnt, err, ae, spd, ltol, lzone, ltop, lfloor;
    logic [1:0] ab;
    logic [1:0] lim;
    logic arr_ev;
    lo = longint'($signed(low_stop));
    hi = longint'($signed(high_stop));
    tgt = longint'($signed(t.target));
    ltol = tol_cfg;
    lzone = zone_cfg;
    ltop = top_speed;
    lfloor = floor_speed;
    lim = lpc_pkg::LIM_NONE;
    arr_ev = 1'b0;
    case (t.req)
      lpc_pkg::REQ_GOTO: begin
        goal = (tgt < lo) ? lo : ((tgt > hi) ? hi : tgt);
        seeking = 1'b1;
        settled = 1'b0;
      end
      lpc_pkg::REQ_STOP: begin
        seeking = 1'b0;
        set_drive(0);
      end
      lpc_pkg::REQ_UP: begin
        seeking = 1'b0;
        set_drive(longint'(jog_speed));
      end
      lpc_pkg::REQ_DOWN: begin
        seeking = 1'b0;
        set_drive(-longint'(jog_speed));
      end
      default: ;
    endcase
    ab = {t.a, t.b};
    pos_count = pos_count + 32'(QUAD[{enc_last, ab}]);
    enc_last = ab;
    cnt = longint'($signed(pos_count));
    if (cnt > hi && speed_now > 0) lim = lpc_pkg::LIM_UPPER;
    if (cnt <= lo && speed_now < 0) lim = lpc_pkg::LIM_LOWER;
    if (t.stop) lim = lpc_pkg::LIM_ENDSTOP;
    if (lim != lpc_pkg::LIM_NONE) begin
      speed_now = 0;
      mode_now = lpc_pkg::MODE_BRAKE;
      seeking = 1'b0;
    end
    if (seeking) begin
      err = goal - cnt;
      ae = (err < 0) ? -err : err;
      if (ae <= ltol) begin
        set_drive(0);
        if (!settled) begin
          settled = 1'b1;
          arr_ev = 1'b1;
        end
      end else begin
        settled = 1'b0;
        if (ae >= lzone || lzone <= ltol) begin
          spd = ltop;
        end else begin
          spd = (ae - ltol) * (ltop - lfloor) / (lzone - ltol) + lfloor;
        end
        if (err < 0) spd = -spd;
        set_drive(spd);
      end
    end
    w.mode = mode_now;
    w.duty = 8'((speed_now < 0) ? -speed_now : speed_now);
    w.position = pos_count;
    w.arrived = settled;
    w.arr_ev = arr_ev;
    w.lim = lim;
    w.seeking = seeking;
  endtask

  task automatic offer_tick(input tick_t t, input logic typed, input lift_word_t want,
                            input bit closing);
    lift_word_t p;
    in_tvalid <= 1'b1;
    in_tuser <= t.req;
    in_tdata <= {3'b000, t.stop, t.b, t.a, t.target};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_motor_word(t, p);
    expected_words.push_back(typed ? want : p);
    if (burst_left > 0) burst_left--;
    if (closing || burst_left == 0) in_tvalid <= 1'b0;
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
  endtask

  task automatic write_registers();
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= reg_plan[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (3'(i))
        lpc_pkg::REG_TOL: tol_cfg = reg_plan[i][15:0];
        lpc_pkg::REG_ZONE: zone_cfg = reg_plan[i][15:0];
        lpc_pkg::REG_MAX: top_speed = reg_plan[i][7:0];
        lpc_pkg::REG_MIN: floor_speed = reg_plan[i][7:0];
        lpc_pkg::REG_MANUAL: jog_speed = reg_plan[i][7:0];
        lpc_pkg::REG_LOWER: low_stop = reg_plan[i];
        lpc_pkg::REG_UPPER: high_stop = reg_plan[i];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  tick_row_t directed_rows [24] = '{
    '{'{lpc_pkg::REQ_TICK, 18'h00000, 1'b0, 1'b0, 1'b0}, 1'b1, RESET_WORD},
    '{'{REQ_SPARE5, 18'h00000, 1'b0, 1'b0, 1'b0}, 1'b1, RESET_WORD},
    '{'{REQ_SPARE7, 18'h1FFFF, 1'b0, 1'b0, 1'b0}, 1'b1, RESET_WORD},
    '{'{lpc_pkg::REQ_GOTO, 18'h1FFFF, 1'b1, 1'b0, 1'b0}, 1'b0, ANY_WORD},
    '{'{lpc_pkg::REQ_GOTO, 18'h20000, 1'b1, 1'b1, 1'b0}, 1'b0, ANY_WORD},
    '{'{lpc_pkg::REQ_TICK, 18'h00000, 1'b0, 1'b1, 1'b0}, 1'b0, ANY_WORD},
    '{'{lpc_pkg::REQ_UP, 18'h00000, 1'b0, 1'b0, 1'b0}, 1'b0, ANY_WORD},
    '{'{lpc_pkg::REQ_TICK, 18'h00000, 1'b0, 1'b0, 1'b1}, 1'b1,
      '{lpc_pkg::MODE_BRAKE, 8'd0, 32'd4, 1'b1, 1'b0, lpc_pkg::LIM_ENDSTOP, 1'b0}},
    '{'{lpc_pkg::REQ_DOWN, 18'h00000, 1'b0, 1'b1, 1'b0}, 1'b0, ANY_WORD},
    '{'{lpc_pkg::REQ_TICK, 18'h00000, 1'b1, 1'b1, 1'b0}, 1'b0, ANY_WORD},
    '{'{lpc_pkg::REQ_TICK, 18'h00000, 1'b1, 1'b0, 1'b0}, 1'b0, ANY_WORD},
    '{'{lpc_pkg::REQ_TICK, 18'h00000, 1'b0, 1'b0, 1'b0}, 1'b1,
      '{lpc_pkg::MODE_BRAKE, 8'd0, 32'd0, 1'b1, 1'b0, lpc_pkg::LIM_LOWER, 1'b0}},
    '{'{lpc_pkg::REQ_TICK, 18'h00000, 1'b1, 1'b1, 1'b0}, 1'b0, ANY_WORD},
    '{'{REQ_SPARE6, 18'h00000, 1'b0, 1'b0, 1'b0}, 1'b0, ANY_WORD},
    '{'{lpc_pkg::REQ_TICK, 18'h00000, 1'b0, 1'b1, 1'b0}, 1'b0, ANY_WORD},
    '{'{lpc_pkg::REQ_TICK, 18'h00000, 1'b1, 1'b0, 1'b0}, 1'b0, ANY_WORD},
    '{'{lpc_pkg::REQ_TICK, 18'h00000, 1'b0, 1'b1, 1'b0}, 1'b0, ANY_WORD},
    '{'{lpc_pkg::REQ_STOP, 18'h00000, 1'b0, 1'b0, 1'b0}, 1'b0, ANY_WORD},
    '{'{lpc_pkg::REQ_GOTO, 18'd300, 1'b0, 1'b0, 1'b0}, 1'b0, ANY_WORD},
    '{'{lpc_pkg::REQ_GOTO, 18'd850, 1'b0, 1'b0, 1'b0}, 1'b0, ANY_WORD},
    '{'{lpc_pkg::REQ_GOTO, 18'h3FFFB, 1'b0, 1'b0, 1'b1}, 1'b0, ANY_WORD},
    '{'{lpc_pkg::REQ_GOTO, 18'h00000, 1'b1, 1'b0, 1'b0}, 1'b0, ANY_WORD},
    '{'{lpc_pkg::REQ_DOWN, 18'h00000, 1'b0, 1'b0, 1'b0}, 1'b0, ANY_WORD},
    '{'{lpc_pkg::REQ_STOP, 18'h00000, 1'b0, 1'b0, 1'b0}, 1'b0, ANY_WORD}
  };

  // result side: random stall pattern, plus one long hold-off on request
  initial begin : result_side
    lift_word_t got, want;
    int hold_left;
    int rx_cycle;
    int rx_mode;
    logic ready_next;
    hold_left = 0;
    rx_cycle = 0;
    rx_mode = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got.mode = out_tdata[1:0];
        got.duty = out_tdata[9:2];
        got.position = out_tdata[41:10];
        got.arrived = out_tdata[42];
        got.arr_ev = out_tdata[43];
        got.lim = out_tdata[45:44];
        got.seeking = out_tdata[46];
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word, position", $signed(got.position), 0);
        end else begin
          want = expected_words.pop_front();
          if (got.mode != want.mode) report_mismatch("drive_mode", got.mode, want.mode);
          if (got.duty != want.duty) report_mismatch("duty", got.duty, want.duty);
          if (got.position != want.position) begin
            report_mismatch("position", $signed(got.position), $signed(want.position));
          end
          if (got.arrived != want.arrived) report_mismatch("arrived", got.arrived, want.arrived);
          if (got.arr_ev != want.arr_ev) begin
            report_mismatch("arrived_event", got.arr_ev, want.arr_ev);
          end
          if (got.lim != want.lim) report_mismatch("limit_event", got.lim, want.lim);
          if (got.seeking != want.seeking) begin
            report_mismatch("positioning", got.seeking, want.seeking);
          end
        end
        words_seen++;
      end
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
      end else if (hold_go) begin
        hold_left = HOLD_CYCLES;
        hold_go = 1'b0;
      end
      case (rx_mode)
        0: ready_next = 1'b1;
        1: ready_next = $urandom_range(0, 1);
        2: ready_next = (rx_cycle % 4 == 0);
        default: ready_next = ($urandom_range(0, 6) != 0);
      endcase
      out_tready <= (hold_left == 0) && ready_next;
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    tick_t t;
    logic [1:0] ab;
    int r;
    tol_cfg = lpc_pkg::RST_TOL;
    zone_cfg = lpc_pkg::RST_ZONE;
    top_speed = lpc_pkg::RST_MAX;
    floor_speed = lpc_pkg::RST_MIN;
    jog_speed = lpc_pkg::RST_MANUAL;
    low_stop = lpc_pkg::RST_LOWER;
    high_stop = lpc_pkg::RST_UPPER;
    enc_last = 2'b00;
    pos_count = '0;
    goal = 0;
    seeking = 1'b0;
    settled = 1'b0;
    speed_now = 0;
    mode_now = lpc_pkg::MODE_COAST;
    burst_left = $urandom_range(1, 12);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) begin
      offer_tick(directed_rows[k].t, directed_rows[k].typed, directed_rows[k].want,
                 k == $size(directed_rows) - 1);
    end
    while (expected_words.size() != 0) @(posedge clk);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          reg_plan[lpc_pkg::REG_TOL] = 18'd0;
          reg_plan[lpc_pkg::REG_ZONE] = 18'h0FFFF;
          reg_plan[lpc_pkg::REG_MAX] = 18'd255;
          reg_plan[lpc_pkg::REG_MIN] = 18'd0;
          reg_plan[lpc_pkg::REG_MANUAL] = 18'd255;
          reg_plan[lpc_pkg::REG_LOWER] = 18'h20000;
          reg_plan[lpc_pkg::REG_UPPER] = 18'h1FFFF;
        end
        1: begin
          // inverted limits, zero top and manual speeds, zone below tolerance
          reg_plan[lpc_pkg::REG_TOL] = 18'h3FFFF;
          reg_plan[lpc_pkg::REG_ZONE] = 18'h30000;
          reg_plan[lpc_pkg::REG_MAX] = 18'h3FF00;
          reg_plan[lpc_pkg::REG_MIN] = 18'd255;
          reg_plan[lpc_pkg::REG_MANUAL] = 18'd0;
          reg_plan[lpc_pkg::REG_LOWER] = 18'h1FFFF;
          reg_plan[lpc_pkg::REG_UPPER] = 18'h20000;
        end
        2: begin
          reg_plan[lpc_pkg::REG_TOL] = 18'd3;
          reg_plan[lpc_pkg::REG_ZONE] = 18'd30;
          reg_plan[lpc_pkg::REG_MAX] = 18'd200;
          reg_plan[lpc_pkg::REG_MIN] = 18'd20;
          reg_plan[lpc_pkg::REG_MANUAL] = 18'd120;
          reg_plan[lpc_pkg::REG_LOWER] = 18'(-40);
          reg_plan[lpc_pkg::REG_UPPER] = 18'd40;
        end
        3: begin
          reg_plan[lpc_pkg::REG_TOL] = 18'd5;
          reg_plan[lpc_pkg::REG_ZONE] = 18'd5;
          reg_plan[lpc_pkg::REG_MAX] = 18'd90;
          reg_plan[lpc_pkg::REG_MIN] = 18'd200;
          reg_plan[lpc_pkg::REG_MANUAL] = 18'd255;
          reg_plan[lpc_pkg::REG_LOWER] = 18'(-20);
          reg_plan[lpc_pkg::REG_UPPER] = 18'd20;
        end
        default: begin
          reg_plan[lpc_pkg::REG_TOL] = {2'($urandom), 16'($urandom_range(0, 10))};
          reg_plan[lpc_pkg::REG_ZONE] = {2'($urandom), 16'($urandom_range(0, 80))};
          reg_plan[lpc_pkg::REG_MAX] = {10'($urandom), 8'($urandom)};
          reg_plan[lpc_pkg::REG_MIN] = {10'($urandom), 8'($urandom)};
          reg_plan[lpc_pkg::REG_MANUAL] = {10'($urandom), 8'($urandom)};
          if ($urandom_range(0, 3) == 0) begin
            reg_plan[lpc_pkg::REG_LOWER] = 18'($urandom);
            reg_plan[lpc_pkg::REG_UPPER] = 18'($urandom);
          end else begin
            reg_plan[lpc_pkg::REG_LOWER] = 18'(-int'($urandom_range(0, 100)));
            reg_plan[lpc_pkg::REG_UPPER] = 18'($urandom_range(0, 100));
          end
        end
      endcase
      reg_plan[REG_SPARE] = 18'($urandom);
      write_registers();
      if (phase == 2) hold_go = 1'b1;

      for (int n = 0; n < PER_PHASE; n++) begin
        r = $urandom_range(0, 99);
        t.req = lpc_pkg::REQ_TICK;
        t.target = 18'($urandom);
        t.stop = ($urandom_range(0, 49) == 0);
        if (r < (seeking ? 2 : 14)) begin
          t.req = lpc_pkg::REQ_GOTO;
          if ($urandom_range(0, 9) != 0) begin
            t.target = 18'(int'(pos_count) + int'($urandom_range(0, 160)) - 80);
          end
        end else if (r < 20) begin
          t.req = $urandom_range(0, 1) ? lpc_pkg::REQ_UP : lpc_pkg::REQ_DOWN;
        end else if (r < 23) begin
          t.req = lpc_pkg::REQ_STOP;
        end else if (r < 25) begin
          t.req = lpc_pkg::REQ_DOWN + 3'($urandom_range(1, 3));
        end
        // encoder follows the motor most of the time, with some noise
        ab = enc_last;
        if (mode_now == lpc_pkg::MODE_FWD && $urandom_range(0, 4) != 0) begin
          ab = FWD_NEXT[enc_last];
        end else if (mode_now == lpc_pkg::MODE_REV && $urandom_range(0, 4) != 0) begin
          ab = BACK_NEXT[enc_last];
        end
        if ($urandom_range(0, 24) == 0) ab = 2'($urandom);
        t.a = ab[1];
        t.b = ab[0];
        offer_tick(t, 1'b0, ANY_WORD, n == PER_PHASE - 1);
      end
      while (expected_words.size() != 0) @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/lpc_pkg.sv
rtl/lpc_ctrl.sv
rtl/lpc_datapath.sv
rtl/lift_position_controller_core.sv
rtl/lpc_checker.sv
test/lift_position_controller_core_test.sv
